>>> sv/sdrw_pkg.sv
// Shared definitions for the segment display RAM writer: action and step codes,
// the sequencer control word and its program table, and the digit segment patterns.
// No dependencies.
package sdrw_pkg;

    localparam int NUM_DIGITS_DEF = 4;
    localparam int COLON_DIGIT    = 1;

    // Action codes of an input beat
    localparam logic [2:0] ACT_WRITE     = 3'd0;
    localparam logic [2:0] ACT_COLON_ON  = 3'd1;
    localparam logic [2:0] ACT_COLON_OFF = 3'd2;
    localparam logic [2:0] ACT_SET_DOT   = 3'd3;
    localparam logic [2:0] ACT_SEND      = 3'd4;

    localparam logic [3:0] BLANK_CODE = 4'd10;

    // Datapath operations selected by the control word
    localparam logic [2:0] OP_IDLE       = 3'd0;
    localparam logic [2:0] OP_DRAW_TENS  = 3'd1;
    localparam logic [2:0] OP_DRAW_UNITS = 3'd2;
    localparam logic [2:0] OP_DOT_ON     = 3'd3;
    localparam logic [2:0] OP_COLON_OFF  = 3'd4;
    localparam logic [2:0] OP_EMIT_CONST = 3'd5;
    localparam logic [2:0] OP_EMIT_RAM   = 3'd6;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE       = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DRAW_TENS  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_DRAW_UNITS = 4'd2;
    localparam logic [STEP_W-1:0] STEP_DOT_ON     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_COLON_OFF  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_F0         = 4'd5;
    localparam logic [STEP_W-1:0] STEP_A3         = 4'd6;
    localparam logic [STEP_W-1:0] STEP_E8         = 4'd7;
    localparam logic [STEP_W-1:0] STEP_HDR0       = 4'd8;
    localparam logic [STEP_W-1:0] STEP_RAM        = 4'd9;
    localparam logic [STEP_W-1:0] STEP_PAD0       = 4'd10;
    localparam logic [STEP_W-1:0] STEP_PAD1       = 4'd11;
    localparam logic [STEP_W-1:0] STEP_C8         = 4'd12;

    typedef struct packed {
        logic [2:0]        op;
        logic [7:0]        data;
        logic              tend;
        logic              last;
        logic [STEP_W-1:0] nxt;
    } ctrl_t;

    // Program table: one control word per step
    function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{op: OP_IDLE, data: 8'h00, tend: 1'b0, last: 1'b0, nxt: STEP_IDLE};
        case (step)
            STEP_DRAW_TENS: begin
                c.op  = OP_DRAW_TENS;
                c.nxt = STEP_DRAW_UNITS;
            end
            STEP_DRAW_UNITS: c.op = OP_DRAW_UNITS;
            STEP_DOT_ON:     c.op = OP_DOT_ON;
            STEP_COLON_OFF:  c.op = OP_COLON_OFF;
            STEP_F0: begin
                c.op   = OP_EMIT_CONST;
                c.data = 8'hF0;
                c.nxt  = STEP_A3;
            end
            STEP_A3: begin
                c.op   = OP_EMIT_CONST;
                c.data = 8'hA3;
                c.nxt  = STEP_E8;
            end
            STEP_E8: begin
                c.op   = OP_EMIT_CONST;
                c.data = 8'hE8;
                c.nxt  = STEP_HDR0;
            end
            STEP_HDR0: begin
                c.op  = OP_EMIT_CONST;
                c.nxt = STEP_RAM;
            end
            STEP_RAM: begin
                c.op  = OP_EMIT_RAM;
                c.nxt = STEP_PAD0;
            end
            STEP_PAD0: begin
                c.op  = OP_EMIT_CONST;
                c.nxt = STEP_PAD1;
            end
            STEP_PAD1: begin
                c.op   = OP_EMIT_CONST;
                c.tend = 1'b1;
                c.nxt  = STEP_C8;
            end
            STEP_C8: begin
                c.op   = OP_EMIT_CONST;
                c.data = 8'hC8;
                c.tend = 1'b1;
                c.last = 1'b1;
            end
            default: c.op = OP_IDLE;
        endcase
        return c;
    endfunction

    // Jump table from the action of an accepted beat to its first step
    function automatic logic [STEP_W-1:0] entry_step(input logic [2:0] action);
        logic [STEP_W-1:0] s;
        case (action)
            ACT_WRITE:     s = STEP_DRAW_TENS;
            ACT_COLON_ON:  s = STEP_DOT_ON;
            ACT_COLON_OFF: s = STEP_COLON_OFF;
            ACT_SET_DOT:   s = STEP_DOT_ON;
            ACT_SEND:      s = STEP_F0;
            default:       s = STEP_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] seg_pattern(input logic [3:0] code);
        logic [31:0] p;
        case (code)
            4'd0:    p = 32'h00888888;
            4'd1:    p = 32'h00008008;
            4'd2:    p = 32'h80800888;
            4'd3:    p = 32'h80008888;
            4'd4:    p = 32'h80088008;
            4'd5:    p = 32'h80088880;
            4'd6:    p = 32'h80888880;
            4'd7:    p = 32'h00008088;
            4'd8:    p = 32'h80888888;
            4'd9:    p = 32'h80088888;
            default: p = 32'h00000000;
        endcase
        return p;
    endfunction

endpackage

>>> sv/sdrw_seg_ram.sv
// Segment RAM: one 32-bit row per digit, byte write enables, registered read.
// Per-byte valid flags make unwritten bytes read as zero after reset.
// Depends on nothing but its parameters.
module sdrw_seg_ram #(
    parameter int NUM_ROWS = 4,
    parameter int ROW_W    = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_row,
    input  logic [3:0]       wr_be,
    input  logic [31:0]      wr_data,
    input  logic [ROW_W-1:0] rd_row,
    output logic [31:0]      rd_data
);

    logic [3:0][7:0] mem [NUM_ROWS];
    logic [3:0]      valid_reg [NUM_ROWS];
    logic [3:0][7:0] rd_word;
    logic [3:0]      rd_valid;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int b = 0; b < 4; b++) begin
                if (wr_be[b]) begin
                    mem[wr_row][b] <= wr_data[8*b +: 8];
                end
            end
        end
        rd_word <= mem[rd_row];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                valid_reg[r] <= 4'b0000;
            end
            rd_valid <= 4'b0000;
        end else begin
            if (wr_en) begin
                valid_reg[wr_row] <= valid_reg[wr_row] | wr_be;
            end
            rd_valid <= valid_reg[rd_row];
        end
    end

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            rd_data[8*b +: 8] = rd_valid[b] ? rd_word[b] : 8'h00;
        end
    end

endmodule

>>> sv/segment_display_ram_writer_top.sv
// Write item: after acceptance, 1 (dot, colon) or 2 (number) sequencer steps.
// Send item: after acceptance, 4*NUM_DIGITS+7 emit steps (23 at 4 digits), one
// output beat per cycle while m_ready is high; the step counter of the sequencer sets it.
// First beat of a send passes the step register (STEP_F0), then the output register.
// Synchronous active-low reset clears the segment RAM (valid flags), dot shadows and
// sequencer at once; no clearing pass. Uses sdrw_pkg and sdrw_seg_ram.
module segment_display_ram_writer_top #(
    parameter int NUM_DIGITS = sdrw_pkg::NUM_DIGITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic       s_pair,
    input  logic [7:0] s_value,
    input  logic       s_leading_zero,
    input  logic       s_blank,
    input  logic [1:0] s_dot_digit,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_frame_byte,
    output logic       m_transfer_end,
    output logic       m_last
);

    localparam int ROW_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam int IDX_W     = ROW_W + 2;
    localparam int RAM_BYTES = NUM_DIGITS * 4;

    logic [sdrw_pkg::STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [3:0]                  tens_code_reg, tens_code_next;
    logic [3:0]                  units_code_reg, units_code_next;
    logic [1:0]                  tens_dig_reg, tens_dig_next;
    logic [1:0]                  units_dig_reg, units_dig_next;
    logic [1:0]                  dot_dig_reg, dot_dig_next;
    logic                        g_reg [NUM_DIGITS];
    logic                        dot_reg [NUM_DIGITS];
    logic                        m_valid_reg, m_valid_next;
    logic [7:0]                  m_byte_reg, m_byte_next;
    logic                        m_tend_reg, m_tend_next;
    logic                        m_last_reg, m_last_next;

    sdrw_pkg::ctrl_t ctrl;

    logic             accept;
    logic             out_free;
    logic             emit;
    logic             idx_end;
    logic [15:0]      prod;
    logic [4:0]       quot;
    logic [7:0]       rem;
    logic [3:0]       tens_mod;
    logic [1:0]       dig;
    logic [3:0]       code;
    logic [31:0]      pat;
    logic             dig_ok;
    logic [ROW_W-1:0] wr_row;
    logic             wr_en;
    logic [3:0]       wr_be;
    logic [31:0]      wr_data;
    logic             sh_we;
    logic             g_new;
    logic             dot_new;
    logic [31:0]      rd_data;
    logic [7:0]       ram_byte;

    assign ctrl     = sdrw_pkg::ctrl_rom(step_reg);
    assign s_ready  = (step_reg == sdrw_pkg::STEP_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = out_free &&
                      (ctrl.op == sdrw_pkg::OP_EMIT_CONST || ctrl.op == sdrw_pkg::OP_EMIT_RAM);
    assign idx_end  = (idx_reg == IDX_W'(RAM_BYTES - 1));

    // Split the value by ten: q = v*205 >> 11 is exact over 8 bits
    assign prod     = {8'h00, s_value} * 16'd205;
    assign quot     = prod[15:11];
    assign rem      = s_value - ({3'b000, quot} << 3) - ({3'b000, quot} << 1);
    assign tens_mod = (quot >= 5'd20) ? 4'(quot - 5'd20) :
                      (quot >= 5'd10) ? 4'(quot - 5'd10) : quot[3:0];

    // Latch the beat and pick digit codes
    always_comb begin
        tens_code_next  = tens_code_reg;
        units_code_next = units_code_reg;
        tens_dig_next   = tens_dig_reg;
        units_dig_next  = units_dig_reg;
        dot_dig_next    = dot_dig_reg;
        if (accept) begin
            tens_dig_next  = {s_pair, 1'b0};
            units_dig_next = {s_pair, 1'b1};
            dot_dig_next   = (s_action == sdrw_pkg::ACT_COLON_ON) ?
                             2'(sdrw_pkg::COLON_DIGIT) : s_dot_digit;
            if (s_blank) begin
                tens_code_next  = sdrw_pkg::BLANK_CODE;
                units_code_next = sdrw_pkg::BLANK_CODE;
            end else if (s_value >= 8'd10) begin
                tens_code_next  = tens_mod;
                units_code_next = rem[3:0];
            end else begin
                tens_code_next  = s_leading_zero ? 4'd0 : sdrw_pkg::BLANK_CODE;
                units_code_next = s_value[3:0];
            end
        end
    end

    // Datapath for the write operations
    always_comb begin
        case (ctrl.op)
            sdrw_pkg::OP_DRAW_TENS:  dig = tens_dig_reg;
            sdrw_pkg::OP_DRAW_UNITS: dig = units_dig_reg;
            sdrw_pkg::OP_DOT_ON:     dig = dot_dig_reg;
            default:                 dig = 2'(sdrw_pkg::COLON_DIGIT);
        endcase
        code    = (ctrl.op == sdrw_pkg::OP_DRAW_TENS) ? tens_code_reg : units_code_reg;
        pat     = sdrw_pkg::seg_pattern(code);
        dig_ok  = (int'(dig) < NUM_DIGITS);
        wr_row  = ROW_W'(dig);
        wr_en   = 1'b0;
        wr_be   = 4'b1000;
        sh_we   = 1'b0;
        g_new   = g_reg[wr_row];
        dot_new = dot_reg[wr_row];
        case (ctrl.op)
            sdrw_pkg::OP_DRAW_TENS, sdrw_pkg::OP_DRAW_UNITS: begin
                wr_en = dig_ok;
                wr_be = 4'b1111;
                sh_we = dig_ok;
                g_new = pat[31];
            end
            sdrw_pkg::OP_DOT_ON: begin
                wr_en   = dig_ok;
                sh_we   = dig_ok;
                dot_new = 1'b1;
            end
            sdrw_pkg::OP_COLON_OFF: begin
                wr_en   = dig_ok;
                sh_we   = dig_ok;
                dot_new = 1'b0;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        // Byte 3 carries only the g segment and the dot
        wr_data = {g_new, 3'b000, dot_new, 3'b000, pat[23:0]};
    end

    // Sequencer and output register
    always_comb begin
        step_next    = step_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_tend_next  = m_tend_reg;
        m_last_next  = m_last_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (ctrl.op)
            sdrw_pkg::OP_IDLE: begin
                if (accept) begin
                    step_next = sdrw_pkg::entry_step(s_action);
                end
            end
            sdrw_pkg::OP_EMIT_CONST, sdrw_pkg::OP_EMIT_RAM: begin
                if (emit) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = (ctrl.op == sdrw_pkg::OP_EMIT_RAM) ? ram_byte : ctrl.data;
                    m_tend_next  = ctrl.tend;
                    m_last_next  = ctrl.last;
                    if (ctrl.op == sdrw_pkg::OP_EMIT_RAM && !idx_end) begin
                        idx_next = idx_reg + 1'b1;
                    end else begin
                        idx_next  = '0;
                        step_next = ctrl.nxt;
                    end
                end
            end
            default: begin
                step_next = ctrl.nxt;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= sdrw_pkg::STEP_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int d = 0; d < NUM_DIGITS; d++) begin
                g_reg[d]   <= 1'b0;
                dot_reg[d] <= 1'b0;
            end
        end else begin
            step_reg    <= step_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (sh_we) begin
                g_reg[wr_row]   <= g_new;
                dot_reg[wr_row] <= dot_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tens_code_reg  <= tens_code_next;
        units_code_reg <= units_code_next;
        tens_dig_reg   <= tens_dig_next;
        units_dig_reg  <= units_dig_next;
        dot_dig_reg    <= dot_dig_next;
        m_byte_reg     <= m_byte_next;
        m_tend_reg     <= m_tend_next;
        m_last_reg     <= m_last_next;
    end

    // Read ahead at the next index so the row for idx_reg is ready each cycle
    sdrw_seg_ram #(
        .NUM_ROWS (NUM_DIGITS),
        .ROW_W    (ROW_W)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_row  (wr_row),
        .wr_be   (wr_be),
        .wr_data (wr_data),
        .rd_row  (idx_next[IDX_W-1:2]),
        .rd_data (rd_data)
    );

    assign ram_byte = rd_data[8*idx_reg[1:0] +: 8];

    assign m_valid        = m_valid_reg;
    assign m_frame_byte   = m_byte_reg;
    assign m_transfer_end = m_tend_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> m_transfer_end)
        else $error("last beat without transfer end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op != sdrw_pkg::OP_EMIT_RAM) |-> (idx_reg == '0))
        else $error("send index not parked outside the RAM loop");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == sdrw_pkg::ACT_SEND) |=>
        (step_reg == sdrw_pkg::STEP_F0))
        else $error("send beat did not start the frame");
`endif

endmodule

>>> verif/segment_display_ram_writer_checker.sv
`timescale 1ns / 100ps
// Checker for the segment display RAM writer: watches both channels, keeps its own copy of
// the segment RAM, predicts every frame beat and compares it with the output beats.
// Depends on sdrw_pkg for the action codes and the colon digit.
module segment_display_ram_writer_checker #(
    parameter int NUM_DIGITS = sdrw_pkg::NUM_DIGITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_action,
    input  logic       s_pair,
    input  logic [7:0] s_value,
    input  logic       s_leading_zero,
    input  logic       s_blank,
    input  logic [1:0] s_dot_digit,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_frame_byte,
    input  logic       m_transfer_end,
    input  logic       m_last,
    output int         mismatches,
    output int         pending
);

    localparam int         RAM_BYTES   = 4 * NUM_DIGITS;
    localparam logic [7:0] DOT_MASK    = 8'h08;
    localparam logic [7:0] G_MASK      = 8'h80;
    localparam logic [3:0] NO_SEGMENTS = 4'd10;
    localparam logic [7:0] TAIL_FRAME  = 8'hC8;
    localparam logic [7:0] HEADER [4]  = '{8'hF0, 8'hA3, 8'hE8, 8'h00};
    localparam logic [31:0] DIGIT_SEGS [11] = '{
        32'h00888888, 32'h00008008, 32'h80800888, 32'h80008888, 32'h80088008,
        32'h80088880, 32'h80888880, 32'h00008088, 32'h80888888, 32'h80088888,
        32'h00000000
    };

    typedef struct packed {
        logic [7:0] data;
        logic       tend;
        logic       last;
    } frame_beat_t;

    logic [7:0]  seg_ram [RAM_BYTES];
    frame_beat_t frame_expect_q [$];
    frame_beat_t want;
    int          beat_no;

    initial begin
        mismatches = 0;
        pending    = 0;
        beat_no    = 0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 50) begin
            $display("%0t ns: mismatch at output beat %0d: %s", $time, beat_no, what);
        end
        mismatches++;
    endtask

    // Write the pattern of one digit; the dot bit of byte 3 survives the redraw
    task automatic paint_digit(input int digit, input logic [3:0] code);
        logic [31:0] pat;
        if (digit >= NUM_DIGITS || code > NO_SEGMENTS) return;
        pat = DIGIT_SEGS[code];
        seg_ram[digit*4 + 0] = pat[7:0];
        seg_ram[digit*4 + 1] = pat[15:8];
        seg_ram[digit*4 + 2] = pat[23:16];
        seg_ram[digit*4 + 3] = (seg_ram[digit*4 + 3] & DOT_MASK) | pat[31:24];
    endtask

    task automatic raise_dot(input int digit);
        if (digit < NUM_DIGITS) seg_ram[digit*4 + 3] |= DOT_MASK;
    endtask

    task automatic predict_frame_bytes(input logic [2:0] action, input logic pair,
                                       input logic [7:0] value, input logic lz,
                                       input logic blank, input logic [1:0] dot);
        int          tens;
        int          units;
        int          v;
        frame_beat_t b;
        tens  = pair * 2;
        units = tens + 1;
        v     = value;
        case (action)
            sdrw_pkg::ACT_WRITE: begin
                if (blank) begin
                    paint_digit(units, NO_SEGMENTS);
                    paint_digit(tens, NO_SEGMENTS);
                end else if (v >= 10) begin
                    paint_digit(units, 4'(v % 10));
                    paint_digit(tens, 4'((v / 10) % 10));
                end else begin
                    paint_digit(tens, lz ? 4'd0 : NO_SEGMENTS);
                    paint_digit(units, 4'(v));
                end
            end
            sdrw_pkg::ACT_COLON_ON:  raise_dot(sdrw_pkg::COLON_DIGIT);
            sdrw_pkg::ACT_COLON_OFF: begin
                if (sdrw_pkg::COLON_DIGIT < NUM_DIGITS)
                    seg_ram[sdrw_pkg::COLON_DIGIT*4 + 3] &= G_MASK;
            end
            sdrw_pkg::ACT_SET_DOT:   raise_dot(dot);
            sdrw_pkg::ACT_SEND: begin
                for (int i = 0; i < RAM_BYTES + 6; i++) begin
                    if (i < 4) b.data = HEADER[i];
                    else if (i < RAM_BYTES + 4) b.data = seg_ram[i - 4];
                    else b.data = 8'h00;
                    b.tend = (i == RAM_BYTES + 5);
                    b.last = 1'b0;
                    frame_expect_q.push_back(b);
                end
                b = '{data: TAIL_FRAME, tend: 1'b1, last: 1'b1};
                frame_expect_q.push_back(b);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < RAM_BYTES; i++) seg_ram[i] = 8'h00;
            frame_expect_q.delete();
            pending <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame_bytes(s_action, s_pair, s_value, s_leading_zero, s_blank,
                                    s_dot_digit);
            end
            if (m_valid && m_ready) begin
                if (frame_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, byte %02h", m_frame_byte));
                end else begin
                    want = frame_expect_q.pop_front();
                    if (m_frame_byte !== want.data)
                        report_mismatch($sformatf("frame_byte %02h, want %02h",
                                                  m_frame_byte, want.data));
                    if (m_transfer_end !== want.tend)
                        report_mismatch($sformatf("transfer_end %b, want %b",
                                                  m_transfer_end, want.tend));
                    if (m_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", m_last, want.last));
                end
                beat_no++;
            end
            pending <= frame_expect_q.size();
        end
    end

endmodule

>>> verif/segment_display_ram_writer_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the segment display RAM writer: clock, reset, directed and random
// input beats, random output stalls with one long hold-off, and the verdict.
// Depends on sdrw_pkg, the block and segment_display_ram_writer_checker.
module segment_display_ram_writer_top_tb;

    localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
    localparam int         RANDOM_ITEMS       = 106;
    localparam int         HOLD_CYCLES        = 400;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [2:0] s_action       = '0;
    logic       s_pair         = 1'b0;
    logic [7:0] s_value        = '0;
    logic       s_leading_zero = 1'b0;
    logic       s_blank        = 1'b0;
    logic [1:0] s_dot_digit    = '0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [7:0] m_frame_byte;
    logic       m_transfer_end;
    logic       m_last;
    logic       hold_off       = 1'b0;
    int         mismatches;
    int         pending;
    int         tx_items       = 0;
    int         rx_beats       = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    segment_display_ram_writer_top u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_pair        (s_pair),
        .s_value       (s_value),
        .s_leading_zero(s_leading_zero),
        .s_blank       (s_blank),
        .s_dot_digit   (s_dot_digit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_byte  (m_frame_byte),
        .m_transfer_end(m_transfer_end),
        .m_last        (m_last)
    );

    segment_display_ram_writer_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_pair        (s_pair),
        .s_value       (s_value),
        .s_leading_zero(s_leading_zero),
        .s_blank       (s_blank),
        .s_dot_digit   (s_dot_digit),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_frame_byte  (m_frame_byte),
        .m_transfer_end(m_transfer_end),
        .m_last        (m_last),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Offer one beat after a random gap, hold it until taken
    task automatic offer_item(input logic [2:0] action, input logic pair,
                              input logic [7:0] value, input logic lz,
                              input logic blank, input logic [1:0] dot);
        int gap;
        gap = ((tx_items / 16) % 3 == 2) ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_action       <= action;
        s_pair         <= pair;
        s_value        <= value;
        s_leading_zero <= lz;
        s_blank        <= blank;
        s_dot_digit    <= dot;
        s_valid        <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tx_items++;
    endtask

    task automatic offer_random_item();
        int         sel;
        logic [2:0] act;
        logic [7:0] val;
        sel = $urandom_range(0, 99);
        if (sel < 40) act = sdrw_pkg::ACT_WRITE;
        else if (sel < 48) act = sdrw_pkg::ACT_COLON_ON;
        else if (sel < 56) act = sdrw_pkg::ACT_COLON_OFF;
        else if (sel < 68) act = sdrw_pkg::ACT_SET_DOT;
        else if (sel < 90) act = sdrw_pkg::ACT_SEND;
        else act = 3'(ACT_RESERVED_FIRST + $urandom_range(0, 2));
        sel = $urandom_range(0, 2);
        if (sel == 0) val = 8'($urandom_range(0, 9));
        else if (sel == 1) val = 8'($urandom_range(10, 99));
        else val = 8'($urandom_range(0, 255));
        offer_item(act, 1'($urandom_range(0, 1)), val, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 5) == 0), 2'($urandom_range(0, 3)));
    endtask

    // Receiver: random stall per beat, released stretches, and the long hold-off
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = ((rx_beats / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
            repeat (gap) begin
                m_ready <= 1'b0;
                @(posedge aclk);
            end
            m_ready <= !hold_off;
            @(posedge aclk);
            while (!(m_valid && m_ready)) begin
                m_ready <= !hold_off;
                @(posedge aclk);
            end
            rx_beats++;
        end
    end

    // Stop draining for a long stretch while the sender keeps offering
    initial begin
        wait (rx_beats >= 60);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: cleared frame, digit range ends, colon, dots, unused actions
        offer_item(sdrw_pkg::ACT_SEND, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b1, 8'd9, 1'b1, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_SEND, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b0, 8'd10, 1'b0, 1'b0, 2'd3);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b1, 8'd99, 1'b1, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_COLON_ON, 1'b1, 8'hFF, 1'b1, 1'b1, 2'd3);
        offer_item(sdrw_pkg::ACT_SEND, 1'b1, 8'hFF, 1'b1, 1'b1, 2'd3);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b0, 8'd255, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b1, 8'd100, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_SET_DOT, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_SET_DOT, 1'b1, 8'd0, 1'b0, 1'b0, 2'd2);
        offer_item(sdrw_pkg::ACT_SET_DOT, 1'b0, 8'd0, 1'b0, 1'b0, 2'd3);
        offer_item(sdrw_pkg::ACT_SEND, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_COLON_OFF, 1'b0, 8'd0, 1'b0, 1'b0, 2'd1);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b1, 8'd42, 1'b0, 1'b1, 2'd0);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b0, 8'd5, 1'b0, 1'b0, 2'd0);
        offer_item(ACT_RESERVED_FIRST, 1'b1, 8'hAA, 1'b1, 1'b1, 2'd1);
        offer_item(3'(ACT_RESERVED_FIRST + 1), 1'b0, 8'h55, 1'b0, 1'b0, 2'd2);
        offer_item(3'(ACT_RESERVED_FIRST + 2), 1'b1, 8'hFF, 1'b1, 1'b1, 2'd3);
        offer_item(sdrw_pkg::ACT_SEND, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_COLON_ON, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_WRITE, 1'b0, 8'd7, 1'b1, 1'b0, 2'd0);
        offer_item(sdrw_pkg::ACT_SEND, 1'b0, 8'd0, 1'b0, 1'b0, 2'd0);

        repeat (RANDOM_ITEMS) offer_random_item();
        s_valid <= 1'b0;

        // Let the last prediction land, drain, then give the sequencer time to settle
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
